// ===== rtl/tcp_pkg.sv =====
// Shared constants and helpers for the tilt controller.
// Holds the CORDIC arctangent table in degrees, Q.20. No dependencies.
`default_nettype none
package tcp_pkg;

  localparam int TABLE_LEN  = 24;
  localparam int TABLE_FRAC = 20;

  localparam int ATAN_DEG_Q20 [TABLE_LEN] = '{
    47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658, 469357,
    234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
    917, 458, 229, 115, 57, 29, 14, 7
  };

  function automatic int cordic_angle(logic [4:0] idx, int unsigned shift);
    int v;
    v = (idx < 5'(TABLE_LEN)) ? ATAN_DEG_Q20[idx] : 0;
    return (v + ((1 << shift) >> 1)) >> shift;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/tcp_mul.sv =====
// Shift-add multiplier, one multiplier bit per cycle.
// Signed 64-bit multiplicand, unsigned 17-bit multiplier. Uses tcp_pkg.
`default_nettype none
module tcp_mul
  import tcp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [63:0] a_i,
  input  logic        [16:0] b_i,
  output logic               done_o,
  output logic signed [63:0] p_o
);

  logic               busy_q, busy_d;
  logic        [4:0]  cnt_q, cnt_d;
  logic signed [63:0] a_q, a_d;
  logic        [16:0] b_q, b_d;
  logic signed [63:0] acc_q, acc_d;
  logic               done_q, done_d;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    a_d    = a_q;
    b_d    = b_q;
    acc_d  = acc_q;
    done_d = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      a_d    = a_i;
      b_d    = b_i;
      acc_d  = '0;
    end else if (busy_q) begin
      if (b_q[0]) acc_d = acc_q + a_q;
      a_d   = a_q <<< 1;
      b_d   = b_q >> 1;
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd16) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    acc_q <= acc_d;
  end

  assign done_o = done_q;
  assign p_o    = acc_q;

endmodule
`default_nettype wire

// ===== rtl/tcp_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Signed dividend, unsigned divisor, quotient truncated toward zero. Uses tcp_pkg.
`default_nettype none
module tcp_div
  import tcp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [63:0] a_i,
  input  logic        [22:0] b_i,
  output logic               done_o,
  output logic signed [63:0] q_o
);

  logic        busy_q, busy_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [63:0] n_q, n_d;
  logic [23:0] rem_q, rem_d;
  logic [22:0] dv_q, dv_d;
  logic        neg_q, neg_d;
  logic        done_q, done_d;
  logic [23:0] trial;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    n_d    = n_q;
    rem_d  = rem_q;
    dv_d   = dv_q;
    neg_d  = neg_q;
    done_d = 1'b0;
    trial  = {rem_q[22:0], n_q[63]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      neg_d  = a_i[63];
      n_d    = a_i[63] ? 64'(-a_i) : 64'(a_i);
      rem_d  = '0;
      dv_d   = b_i;
    end else if (busy_q) begin
      if (trial >= {1'b0, dv_q}) begin
        rem_d = trial - {1'b0, dv_q};
        n_d   = {n_q[62:0], 1'b1};
      end else begin
        rem_d = trial;
        n_d   = {n_q[62:0], 1'b0};
      end
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd63) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q   <= n_d;
    rem_q <= rem_d;
    dv_q  <= dv_d;
    neg_q <= neg_d;
  end

  assign done_o = done_q;
  assign q_o    = neg_q ? -$signed(n_q) : $signed(n_q);

endmodule
`default_nettype wire

// ===== rtl/tilt_complementary_pid.sv =====
// Tilt balance controller: deadbanded gyro, CORDIC accel tilt, complementary filter, PID.
// Each transaction runs through the serial divider and multiplier; the gain multiplies
// and the output division are skipped when the error is outside the window.
// One transaction at a time; the next is taken once the result has been moved into the output register.
// Asynchronous active-low reset restores register defaults and zeroes tilt and integral.
// Depends on tcp_pkg, tcp_mul, tcp_div.
`default_nettype none
module tilt_complementary_pid
  import tcp_pkg::*;
#(
  parameter int CORDIC_STEPS    = 16,
  parameter int ANGLE_FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] gyro_rate_raw_i,
  input  logic signed [15:0] accel_x_raw_i,
  input  logic signed [15:0] accel_z_raw_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] drive_level_o,
  output logic signed [31:0] fused_tilt_o,
  output logic               in_window_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic        [2:0]  cfg_index_i,
  input  logic        [24:0] cfg_data_i
);

  localparam int NCS    = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;
  localparam int CW     = $clog2(NCS);
  localparam int AW     = ANGLE_FRAC_BITS + 9;
  localparam int XW     = 35;
  localparam int TSHIFT = TABLE_FRAC - ANGLE_FRAC_BITS;
  localparam int SH_DN  = (ANGLE_FRAC_BITS >= 16) ? ANGLE_FRAC_BITS - 16 : 0;
  localparam int SH_UP  = (ANGLE_FRAC_BITS < 16) ? 16 - ANGLE_FRAC_BITS : 0;
  localparam logic signed [39:0] CV_HALF = (40'sd1 <<< SH_DN) >>> 1;

  localparam logic [2:0] REG_KP = 3'd0, REG_KI = 3'd1, REG_KD = 3'd2, REG_F = 3'd3;
  localparam logic [2:0] REG_DT = 3'd4, REG_DIV = 3'd5, REG_SP = 3'd6, REG_DB = 3'd7;

  localparam logic signed [63:0] S48_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [63:0] S48_MIN = -64'sh0000_8000_0000_0000;
  localparam logic signed [63:0] S32_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] S32_MIN = -64'sh0000_0000_8000_0000;
  localparam logic signed [63:0] DRV_MAX = 64'sd32767;
  localparam logic signed [63:0] DRV_MIN = -64'sd32767;
  localparam logic signed [32:0] DEG_1   = 33'sd65536;
  localparam logic signed [32:0] DEG_15  = 33'sd983040;

  typedef enum logic [13:0] {
    ST_IDLE     = 14'b00000000000001,
    ST_RATE     = 14'b00000000000010,
    ST_CORD     = 14'b00000000000100,
    ST_MUL_DT   = 14'b00000000001000,
    ST_MUL_KEEP = 14'b00000000010000,
    ST_MUL_ACC  = 14'b00000000100000,
    ST_DIV_D    = 14'b00000001000000,
    ST_MUL_INT  = 14'b00000010000000,
    ST_MUL_KI   = 14'b00000100000000,
    ST_MUL_KD   = 14'b00001000000000,
    ST_MUL_KP   = 14'b00010000000000,
    ST_DIV_OUT  = 14'b00100000000000,
    ST_DONE     = 14'b01000000000000,
    ST_SPARE    = 14'b10000000000000
  } state_e;

  state_e st_q, st_d;

  logic [15:0] kp_q, ki_q, kd_q, f_q, dt_q;
  logic [11:0] dv_q;
  logic signed [24:0] sp_q;
  logic [7:0]  db_q;

  logic signed [31:0] est_q, est_d;
  logic signed [47:0] int_q, int_d;
  logic signed [47:0] d_q, d_d;
  logic signed [31:0] p_q, p_d;
  logic signed [31:0] rate_q, rate_d;
  logic signed [63:0] tmp_q, tmp_d;
  logic signed [63:0] sum_q, sum_d;
  logic               gneg_q, gneg_d;
  logic               win_q, win_d;
  logic signed [15:0] drv_q, drv_d;
  logic signed [XW-1:0] x_q, x_d, z_q, z_d;
  logic signed [AW-1:0] ang_q, ang_d;
  logic signed [9:0]  base_q, base_d;
  logic               skip_q, skip_d;
  logic [CW-1:0]      cnt_q, cnt_d;

  logic               out_valid_q, out_valid_d;
  logic signed [15:0] out_drv_q, out_drv_d;
  logic signed [31:0] out_tilt_q, out_tilt_d;
  logic               out_win_q, out_win_d;

  logic               mul_go_q, mul_go_d, div_go_q, div_go_d;
  logic signed [63:0] mul_a_q, mul_a_d, div_a_q, div_a_d;
  logic        [16:0] mul_b_q, mul_b_d;
  logic        [22:0] div_b_q, div_b_d;
  logic               mul_done, div_done;
  logic signed [63:0] mul_p, div_q;

  logic               in_acc;
  logic        [16:0] gmag;
  logic        [14:0] m;
  logic        [17:0] m7;
  logic        [16:0] dt_eff;
  logic        [11:0] dv_eff;
  logic signed [XW-1:0] xs, zs;
  logic signed [AW-1:0] tstep;
  logic signed [39:0] ang_ext, conv;
  logic signed [31:0] accdeg;
  logic signed [63:0] wide, pn;
  logic signed [32:0] err, aerr;
  logic signed [16:0] ax_n, az_n;

  tcp_mul u_mul (
    .clk_i, .rst_ni,
    .start_i(mul_go_q), .a_i(mul_a_q), .b_i(mul_b_q),
    .done_o(mul_done), .p_o(mul_p)
  );

  tcp_div u_div (
    .clk_i, .rst_ni,
    .start_i(div_go_q), .a_i(div_a_q), .b_i(div_b_q),
    .done_o(div_done), .q_o(div_q)
  );

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (st_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;

  assign dt_eff = (dt_q == '0) ? 17'd1 : {1'b0, dt_q};
  assign dv_eff = (dv_q == '0) ? 12'd1 : dv_q;

  assign gmag = gyro_rate_raw_i[15] ? 17'(-17'(gyro_rate_raw_i)) : 17'(gyro_rate_raw_i);
  assign m    = (gmag > 17'd32767) ? 15'd32767 :
                ((gmag < 17'(db_q)) ? 15'd0 : gmag[14:0]);
  assign m7   = (18'(m) << 3) - 18'(m);

  assign ax_n = -17'(accel_x_raw_i);
  assign az_n = -17'(accel_z_raw_i);

  assign xs    = x_q >>> cnt_q;
  assign zs    = z_q >>> cnt_q;
  assign tstep = AW'(cordic_angle(5'(cnt_q), TSHIFT));

  assign ang_ext = 40'(ang_q);
  assign conv    = (SH_DN != 0) ? ((ang_ext + CV_HALF) >>> SH_DN) : (ang_ext <<< SH_UP);
  assign accdeg  = skip_q ? 32'sd5898240 :
                   (32'sd5898240 - 32'(conv) - (32'(base_q) <<< 16));

  assign err  = 33'(p_q) - 33'(sp_q);
  assign aerr = err[32] ? -err : err;

  always_comb begin
    st_d     = st_q;
    est_d    = est_q;
    int_d    = int_q;
    d_d      = d_q;
    p_d      = p_q;
    rate_d   = rate_q;
    tmp_d    = tmp_q;
    sum_d    = sum_q;
    gneg_d   = gneg_q;
    win_d    = win_q;
    drv_d    = drv_q;
    x_d      = x_q;
    z_d      = z_q;
    ang_d    = ang_q;
    base_d   = base_q;
    skip_d   = skip_q;
    cnt_d    = cnt_q;
    mul_go_d = 1'b0;
    div_go_d = 1'b0;
    mul_a_d  = mul_a_q;
    mul_b_d  = mul_b_q;
    div_a_d  = div_a_q;
    div_b_d  = div_b_q;
    wide     = '0;
    pn       = '0;
    out_valid_d = out_valid_q && out_stall_i;
    out_drv_d   = out_drv_q;
    out_tilt_d  = out_tilt_q;
    out_win_d   = out_win_q;

    unique case (st_q)
      ST_IDLE: begin
        if (in_acc) begin
          gneg_d   = gyro_rate_raw_i[15];
          div_a_d  = 64'({m7, 16'b0}) + 64'sd50;
          div_b_d  = 23'd100;
          div_go_d = 1'b1;
          skip_d   = (accel_x_raw_i == '0) && (accel_z_raw_i == '0);
          cnt_d    = '0;
          ang_d    = '0;
          if (accel_x_raw_i[15]) begin
            base_d = accel_z_raw_i[15] ? -10'sd180 : 10'sd180;
            x_d    = XW'(ax_n) <<< 16;
            z_d    = XW'(az_n) <<< 16;
          end else begin
            base_d = '0;
            x_d    = XW'(accel_x_raw_i) <<< 16;
            z_d    = XW'(accel_z_raw_i) <<< 16;
          end
          st_d = ST_RATE;
        end
      end
      ST_RATE: begin
        if (div_done) begin
          rate_d = gneg_q ? -32'(div_q) : 32'(div_q);
          st_d   = ST_CORD;
        end
      end
      ST_CORD: begin
        if (!z_q[XW-1]) begin
          x_d   = x_q + zs;
          z_d   = z_q - xs;
          ang_d = ang_q + tstep;
        end else begin
          x_d   = x_q - zs;
          z_d   = z_q + xs;
          ang_d = ang_q - tstep;
        end
        cnt_d = cnt_q + CW'(1);
        if (cnt_q == CW'(NCS - 1)) begin
          mul_a_d  = 64'(rate_q);
          mul_b_d  = dt_eff;
          mul_go_d = 1'b1;
          st_d     = ST_MUL_DT;
        end
      end
      ST_MUL_DT: begin
        if (mul_done) begin
          wide     = 64'(est_q) + ((mul_p + 64'sd32768) >>> 16);
          mul_a_d  = wide;
          mul_b_d  = 17'd65536 - 17'(f_q);
          mul_go_d = 1'b1;
          st_d     = ST_MUL_KEEP;
        end
      end
      ST_MUL_KEEP: begin
        if (mul_done) begin
          tmp_d    = mul_p;
          mul_a_d  = 64'(accdeg);
          mul_b_d  = 17'(f_q);
          mul_go_d = 1'b1;
          st_d     = ST_MUL_ACC;
        end
      end
      ST_MUL_ACC: begin
        if (mul_done) begin
          wide = (tmp_q + mul_p + 64'sd32768) >>> 16;
          pn   = (wide > S32_MAX) ? S32_MAX : ((wide < S32_MIN) ? S32_MIN : wide);
          p_d      = 32'(pn);
          div_a_d  = (pn - 64'(est_q)) <<< 16;
          div_b_d  = 23'(dt_eff);
          div_go_d = 1'b1;
          est_d    = 32'(pn);
          st_d     = ST_DIV_D;
        end
      end
      ST_DIV_D: begin
        if (div_done) begin
          wide     = (div_q > S48_MAX) ? S48_MAX : ((div_q < S48_MIN) ? S48_MIN : div_q);
          d_d      = 48'(wide);
          mul_a_d  = 64'(p_q);
          mul_b_d  = dt_eff;
          mul_go_d = 1'b1;
          st_d     = ST_MUL_INT;
        end
      end
      ST_MUL_INT: begin
        if (mul_done) begin
          wide  = 64'(int_q) + ((mul_p + 64'sd32768) >>> 16);
          pn    = (wide > S48_MAX) ? S48_MAX : ((wide < S48_MIN) ? S48_MIN : wide);
          int_d = 48'(pn);
          win_d = (aerr >= DEG_1) && (aerr <= DEG_15);
          sum_d = '0;
          drv_d = '0;
          if ((aerr >= DEG_1) && (aerr <= DEG_15)) begin
            mul_a_d  = pn;
            mul_b_d  = 17'(ki_q);
            mul_go_d = 1'b1;
            st_d     = ST_MUL_KI;
          end else begin
            st_d = ST_DONE;
          end
        end
      end
      ST_MUL_KI: begin
        if (mul_done) begin
          sum_d    = sum_q + (mul_p >>> 2);
          mul_a_d  = 64'(d_q);
          mul_b_d  = 17'(kd_q);
          mul_go_d = 1'b1;
          st_d     = ST_MUL_KD;
        end
      end
      ST_MUL_KD: begin
        if (mul_done) begin
          sum_d    = sum_q + (mul_p >>> 2);
          mul_a_d  = 64'(p_q);
          mul_b_d  = 17'(kp_q);
          mul_go_d = 1'b1;
          st_d     = ST_MUL_KP;
        end
      end
      ST_MUL_KP: begin
        if (mul_done) begin
          div_a_d  = sum_q + (mul_p >>> 2);
          div_b_d  = {dv_eff, 11'b0};
          div_go_d = 1'b1;
          st_d     = ST_DIV_OUT;
        end
      end
      ST_DIV_OUT: begin
        if (div_done) begin
          wide  = (div_q > DRV_MAX) ? DRV_MAX : ((div_q < DRV_MIN) ? DRV_MIN : div_q);
          drv_d = 16'(wide);
          st_d  = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_drv_d   = drv_q;
          out_tilt_d  = p_q;
          out_win_d   = win_q;
          st_d        = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      est_q       <= '0;
      int_q       <= '0;
      out_valid_q <= 1'b0;
      mul_go_q    <= 1'b0;
      div_go_q    <= 1'b0;
      kp_q        <= 16'd4096;
      ki_q        <= 16'd410;
      kd_q        <= 16'd205;
      f_q         <= 16'd6554;
      dt_q        <= 16'd655;
      dv_q        <= 12'd170;
      sp_q        <= '0;
      db_q        <= 8'd10;
    end else begin
      st_q        <= st_d;
      est_q       <= est_d;
      int_q       <= int_d;
      out_valid_q <= out_valid_d;
      mul_go_q    <= mul_go_d;
      div_go_q    <= div_go_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          REG_KP:  kp_q <= cfg_data_i[15:0];
          REG_KI:  ki_q <= cfg_data_i[15:0];
          REG_KD:  kd_q <= cfg_data_i[15:0];
          REG_F:   f_q  <= cfg_data_i[15:0];
          REG_DT:  dt_q <= cfg_data_i[15:0];
          REG_DIV: dv_q <= cfg_data_i[11:0];
          REG_SP:  sp_q <= cfg_data_i;
          REG_DB:  db_q <= cfg_data_i[7:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    d_q        <= d_d;
    p_q        <= p_d;
    rate_q     <= rate_d;
    tmp_q      <= tmp_d;
    sum_q      <= sum_d;
    gneg_q     <= gneg_d;
    win_q      <= win_d;
    drv_q      <= drv_d;
    x_q        <= x_d;
    z_q        <= z_d;
    ang_q      <= ang_d;
    base_q     <= base_d;
    skip_q     <= skip_d;
    cnt_q      <= cnt_d;
    mul_a_q    <= mul_a_d;
    mul_b_q    <= mul_b_d;
    div_a_q    <= div_a_d;
    div_b_q    <= div_b_d;
    out_drv_q  <= out_drv_d;
    out_tilt_q <= out_tilt_d;
    out_win_q  <= out_win_d;
  end

  assign out_valid_o   = out_valid_q;
  assign drive_level_o = out_drv_q;
  assign fused_tilt_o  = out_tilt_q;
  assign in_window_o   = out_win_q;

endmodule
`default_nettype wire
